// ----- hw/rtl/setq_pkg.sv -----
// Shared constants for the sorted event timer queue.
// Depends on nothing; the interfaces and the top level import it.
package setq_pkg;

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 4;
   localparam int DELTA_W  = 48;
   localparam int TIME_W   = 63;
   localparam int DUE_W    = 64;

   // Most dispatch beats produced by one run request.
   localparam int RESULTS_CAP = 16;
   localparam int POP_W       = $clog2(RESULTS_CAP + 1);

   localparam logic [FUNC_W-1:0] FUNC_SCHED  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;

   localparam logic [DUE_W-1:0] DUE_EMPTY = '1;

endpackage

// ----- hw/rtl/setq_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on setq_pkg for the field widths.
interface setq_req_if;
   import setq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [ID_W-1:0]           event_id;
   logic signed [DELTA_W-1:0] offset_ns;
   logic [TIME_W-1:0]         now_ns;

   modport source  (output valid, func, event_id, offset_ns, now_ns, input ready);
   modport sink    (input valid, func, event_id, offset_ns, now_ns, output ready);
   modport monitor (input valid, func, event_id, offset_ns, now_ns, ready);
endinterface

interface setq_rsp_if;
   import setq_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ID_W-1:0]   fired_id;
   logic [TIME_W-1:0] late_ns;
   logic [DUE_W-1:0]  next_due;
   logic              last;

   modport source  (output valid, kind, fired_id, late_ns, next_due, last, input ready);
   modport sink    (input valid, kind, fired_id, late_ns, next_due, last, output ready);
   modport monitor (input valid, kind, fired_id, late_ns, next_due, last, ready);
endinterface

// ----- hw/rtl/setq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module setq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sorted_event_timer_queue_unit.sv -----
// Top level of the sorted event timer queue: control sequencer and entry memory.
// Depends on setq_pkg, setq_if (setq_req_if, setq_rsp_if) and setq_ram.
//
// The queue keeps its pending events as a sorted list of (due time, slot) entries in
// one synchronous memory with one read and one write port, plus a busy flag per slot,
// an entry count and a copy of the head entry in registers. Requests are handled one at
// a time. To cancel a queued slot, the sequencer reads each of the N queued entries
// once to find the slot and writes the followers one place down. A schedule adds an
// insert walk that reads each entry ahead of the insert point and moves each entry
// behind it one place up. A run request dispatches up to sixteen due events, one
// response beat each, or a single empty beat when none is due; every pop goes through
// the removal walk. The request side is ready only while the sequencer is idle; a
// finished response beat sits in an output register, so the next request is taken while
// that beat waits. Slot numbers at or above EVENT_SLOTS and the unused function code are
// acknowledged without effect. Every response carries the earliest pending due time, all
// ones when the queue is empty.
module sorted_event_timer_queue_unit #(
   parameter int EVENT_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   setq_req_if.sink    req,
   setq_rsp_if.source  rsp
);
   import setq_pkg::*;

   localparam int SLOT_W  = $clog2(EVENT_SLOTS);
   localparam int CNT_W   = $clog2(EVENT_SLOTS + 1);
   localparam int ENTRY_W = DUE_W + SLOT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_RM_RD,
      S_RM_CHK,
      S_IN_RD,
      S_IN_CHK,
      S_SH_RD,
      S_SH_WR,
      S_HEAD_RD,
      S_HEAD_WR,
      S_REPLY
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     k_ff;
   logic                 found_ff;
   logic [EVENT_SLOTS-1:0] busy_ff;
   logic [DUE_W-1:0]     head_due_ff;
   logic [SLOT_W-1:0]    head_slot_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [DUE_W-1:0]     due_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    late_ff;
   logic                 fire_ff;
   logic [POP_W-1:0]     pops_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [ID_W-1:0]      rsp_fired_id_ff;
   logic [TIME_W-1:0]    rsp_late_ns_ff;
   logic [DUE_W-1:0]     rsp_next_due_ff;
   logic                 rsp_last_ff;

   logic                 ram_wr_en;
   logic [SLOT_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [SLOT_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   logic [DUE_W-1:0]     rd_due;
   logic [SLOT_W-1:0]    rd_slot;
   logic [CNT_W-1:0]     idx_dec;
   logic [CNT_W-1:0]     k_dec;
   logic [DUE_W:0]       sum_due;
   logic [DUE_W-1:0]     new_due;
   logic [SLOT_W-1:0]    req_slot;
   logic                 req_id_ok;
   logic                 out_free;
   logic                 more_due;

   assign rd_due  = ram_rd_data[ENTRY_W-1:SLOT_W];
   assign rd_slot = ram_rd_data[SLOT_W-1:0];
   assign idx_dec = idx_ff - CNT_W'(1);
   assign k_dec   = k_ff - CNT_W'(1);

   // Due time of a schedule: now plus the sign-extended delay, clamped at zero.
   assign sum_due = {2'b00, req.now_ns} + {{(DUE_W + 1 - DELTA_W){req.offset_ns[DELTA_W-1]}},
                                           req.offset_ns};
   assign new_due = sum_due[DUE_W] ? '0 : sum_due[DUE_W-1:0];

   assign req_slot  = SLOT_W'(req.event_id);
   assign req_id_ok = (32'(req.event_id) < EVENT_SLOTS);

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Another pop follows when the cap is not reached and the new head is due.
   assign more_due = fire_ff && (pops_ff != POP_W'(RESULTS_CAP)) && (cnt_ff != '0) &&
                     (head_due_ff <= {1'b0, now_ff});

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.fired_id = rsp_fired_id_ff;
   assign rsp.late_ns  = rsp_late_ns_ff;
   assign rsp.next_due = rsp_next_due_ff;
   assign rsp.last     = rsp_last_ff;

   // Memory port control. Reads and writes of the same entry never fall in one cycle.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[SLOT_W-1:0];
      ram_wr_data = {due_ff, slot_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[SLOT_W-1:0];
      case (state_ff)
         S_RM_RD: begin
            ram_rd_en = (idx_ff != cnt_ff);
         end
         S_RM_CHK: begin
            ram_wr_en   = found_ff;
            ram_wr_addr = idx_dec[SLOT_W-1:0];
            ram_wr_data = ram_rd_data;
         end
         S_IN_RD: begin
            ram_rd_en = (idx_ff != cnt_ff);
         end
         S_SH_RD: begin
            if (k_ff == idx_ff) begin
               ram_wr_en = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = k_dec[SLOT_W-1:0];
            end
         end
         S_SH_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff[SLOT_W-1:0];
            ram_wr_data = ram_rd_data;
         end
         S_HEAD_RD: begin
            ram_rd_en   = (cnt_ff != '0);
            ram_rd_addr = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         busy_ff      <= '0;
         head_due_ff  <= DUE_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The beat drains unless a new one is loaded into the output register.
         if (rsp.ready && !((state_ff == S_REPLY) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  func_ff  <= req.func;
                  slot_ff  <= req_slot;
                  due_ff   <= new_due;
                  now_ff   <= req.now_ns;
                  fire_ff  <= 1'b0;
                  pops_ff  <= '0;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  if (req.func == FUNC_RUN) begin
                     if ((cnt_ff != '0) && (head_due_ff <= {1'b0, req.now_ns})) begin
                        state_ff <= S_POP;
                     end else begin
                        state_ff <= S_REPLY;
                     end
                  end else if (req_id_ok && busy_ff[req_slot] &&
                               ((req.func == FUNC_SCHED) || (req.func == FUNC_CANCEL))) begin
                     state_ff <= S_RM_RD;
                  end else if (req_id_ok && (req.func == FUNC_SCHED)) begin
                     state_ff <= S_IN_RD;
                  end else begin
                     state_ff <= S_REPLY;
                  end
               end
            end
            S_POP: begin
               // Take the head entry out through the ordinary removal walk.
               slot_ff  <= head_slot_ff;
               late_ff  <= TIME_W'({1'b0, now_ff} - head_due_ff);
               fire_ff  <= 1'b1;
               pops_ff  <= pops_ff + POP_W'(1);
               idx_ff   <= '0;
               found_ff <= 1'b0;
               state_ff <= S_RM_RD;
            end
            S_RM_RD: begin
               if (idx_ff == cnt_ff) begin
                  cnt_ff           <= cnt_ff - CNT_W'(1);
                  busy_ff[slot_ff] <= 1'b0;
                  idx_ff           <= '0;
                  if (func_ff == FUNC_SCHED) begin
                     state_ff <= S_IN_RD;
                  end else begin
                     state_ff <= S_HEAD_RD;
                  end
               end else begin
                  state_ff <= S_RM_CHK;
               end
            end
            S_RM_CHK: begin
               if (!found_ff && (rd_slot == slot_ff)) begin
                  found_ff <= 1'b1;
               end
               idx_ff   <= idx_ff + CNT_W'(1);
               state_ff <= S_RM_RD;
            end
            S_IN_RD: begin
               if (idx_ff == cnt_ff) begin
                  k_ff     <= cnt_ff;
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_IN_CHK;
               end
            end
            S_IN_CHK: begin
               // Insert ahead of the first entry due at or after the new time.
               if (rd_due >= due_ff) begin
                  k_ff     <= cnt_ff;
                  state_ff <= S_SH_RD;
               end else begin
                  idx_ff   <= idx_ff + CNT_W'(1);
                  state_ff <= S_IN_RD;
               end
            end
            S_SH_RD: begin
               if (k_ff == idx_ff) begin
                  cnt_ff           <= cnt_ff + CNT_W'(1);
                  busy_ff[slot_ff] <= 1'b1;
                  state_ff         <= S_HEAD_RD;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               k_ff     <= k_dec;
               state_ff <= S_SH_RD;
            end
            S_HEAD_RD: begin
               if (cnt_ff == '0) begin
                  head_due_ff <= DUE_EMPTY;
                  state_ff    <= S_REPLY;
               end else begin
                  state_ff <= S_HEAD_WR;
               end
            end
            S_HEAD_WR: begin
               head_due_ff  <= rd_due;
               head_slot_ff <= rd_slot;
               state_ff     <= S_REPLY;
            end
            S_REPLY: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_kind_ff     <= fire_ff;
                  rsp_fired_id_ff <= fire_ff ? ID_W'(slot_ff) : '0;
                  rsp_late_ns_ff  <= fire_ff ? late_ff : '0;
                  rsp_next_due_ff <= head_due_ff;
                  rsp_last_ff     <= !more_due;
                  if (more_due) begin
                     state_ff <= S_POP;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   setq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (EVENT_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   // The entry count always matches the number of busy slots.
   assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == int'(cnt_ff))
      else $error("entry count differs from busy slot count");

   // The count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= EVENT_SLOTS)
      else $error("entry count overflow");

   // While idle, the head copy says empty exactly when the list is empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((cnt_ff == '0) == (head_due_ff == DUE_EMPTY)))
      else $error("head due time out of step with entry count");

   // A dispatch beat never reports more pops than the cap allows.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (pops_ff < POP_W'(RESULTS_CAP)))
      else $error("pop cap exceeded");
`endif

endmodule

// ----- bench/timer_queue_checker.sv -----
// Checker for the sorted event timer queue: watches both channels, predicts responses.
// Depends on setq_pkg and setq_if; hands a failure count back to the testbench top.
module timer_queue_checker (
   input  logic         clock,
   input  logic         reset,
   setq_req_if.monitor  req_mon,
   setq_rsp_if.monitor  rsp_mon,
   output int           fail_count,
   output int           pending_count
);
   import setq_pkg::*;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   fired_id;
      logic [TIME_W-1:0] late_ns;
      logic [DUE_W-1:0]  next_due;
      logic              last;
   } rsp_beat_type;

   logic [DUE_W-1:0] due_time [16];
   logic             queued   [16];
   logic [ID_W-1:0]  order    [$];
   rsp_beat_type     expected_beats [$];

   function automatic logic [DUE_W-1:0] earliest_due();
      return (order.size() == 0) ? DUE_EMPTY : due_time[order[0]];
   endfunction

   function automatic void drop_slot(input logic [ID_W-1:0] slot);
      foreach (order[i]) begin
         if (order[i] == slot) begin
            order.delete(i);
            break;
         end
      end
      queued[slot] = 1'b0;
   endfunction

   function automatic void push_beat(input logic k, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] late, input logic fin);
      rsp_beat_type b;
      b.kind = k; b.fired_id = id; b.late_ns = late;
      b.next_due = earliest_due(); b.last = fin;
      expected_beats.push_back(b);
   endfunction

   // Advance the queue model by one accepted request beat.
   task automatic apply_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                                input logic signed [DELTA_W-1:0] delta,
                                input logic [TIME_W-1:0] now);
      int               pops;
      int               pos;
      logic [DUE_W-1:0] due;
      logic [DUE_W-1:0] mag;
      pops = 0;
      if (f == FUNC_RUN) begin
         while (pops < RESULTS_CAP && order.size() > 0 && due_time[order[0]] <= now) begin
            logic [ID_W-1:0] slot;
            slot = order[0];
            due  = due_time[slot];
            drop_slot(slot);
            push_beat(1'b1, slot, TIME_W'(now - due), 1'b0);
            pops++;
         end
         if (pops == 0) push_beat(1'b0, '0, '0, 1'b1);
         else expected_beats[$].last = 1'b1;
      end else begin
         if (f == FUNC_SCHED) begin
            if (delta < 0) begin
               mag = DUE_W'(-delta);
               mag = mag & ((64'd1 << 48) - 1);
               due = (now >= mag) ? (DUE_W'(now) - mag) : '0;
            end else begin
               due = DUE_W'(now) + DUE_W'(delta);
            end
            if (queued[id]) drop_slot(id);
            due_time[id] = due;
            pos = 0;
            while (pos < order.size() && due_time[order[pos]] < due) pos++;
            order.insert(pos, id);
            queued[id] = 1'b1;
         end else if (f == FUNC_CANCEL) begin
            if (queued[id]) drop_slot(id);
         end
         push_beat(1'b0, '0, '0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         pending_count = 0;
         order.delete();
         expected_beats.delete();
         foreach (queued[i]) queued[i] = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.func, req_mon.event_id, req_mon.offset_ns, req_mon.now_ns);
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_beat_type got, want;
            got = {rsp_mon.kind, rsp_mon.fired_id, rsp_mon.late_ns, rsp_mon.next_due,
                   rsp_mon.last};
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got.kind != want.kind || got.fired_id != want.fired_id ||
                   got.late_ns != want.late_ns || got.next_due != want.next_due ||
                   got.last != want.last) begin
                  $display("%0t: response mismatch, expected k=%0d id=%0d late=%0d next=%h last=%0d",
                           $time, want.kind, want.fired_id, want.late_ns, want.next_due,
                           want.last);
                  $display("%0t:                      actual k=%0d id=%0d late=%0d next=%h last=%0d",
                           $time, got.kind, got.fired_id, got.late_ns, got.next_due,
                           got.last);
                  fail_count++;
               end
            end
         end
         pending_count = expected_beats.size();
      end
   end
endmodule

// ----- bench/testbench.sv -----
// Testbench top for the sorted event timer queue: clock, reset, stimulus and verdict.
// Depends on setq_pkg, setq_if, the unit under test and timer_queue_checker.
module testbench;
   import setq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic [TIME_W-1:0] sim_now = '0;

   setq_req_if req_ch ();
   setq_rsp_if rsp_ch ();

   sorted_event_timer_queue_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   timer_queue_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.monitor),
      .rsp_mon       (rsp_ch.monitor),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Drives one request beat and holds it until the block accepts it. Random idle
   // cycles come first, so gaps land on every phase of the block's work. Valid stays
   // high on return; the next call or the caller takes it down.
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                               input logic [DELTA_W-1:0] delta,
                               input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.event_id  <= id;
      req_ch.offset_ns <= delta;
      req_ch.now_ns    <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random request: mostly schedules and runs with a slowly advancing clock, so the
   // queue fills, drains and carries late events. Deltas are small mostly, large at times.
   task automatic send_random();
      logic [DELTA_W-1:0] delta;
      logic [FUNC_W-1:0]  f;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 50) f = FUNC_SCHED;
      else if (pick < 65) f = FUNC_CANCEL;
      else if (pick < 97) f = FUNC_RUN;
      else f = FUNC_SPARE;
      if ($urandom_range(9) == 0) delta = DELTA_W'({$urandom, $urandom});
      else delta = DELTA_W'($signed($urandom_range(400)) - 100);
      sim_now = sim_now + TIME_W'($urandom_range(60));
      if ($urandom_range(49) == 0) sim_now = TIME_W'({$urandom, $urandom});
      send_request(f, ID_W'($urandom_range(15)), delta, sim_now);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_SCHED;
      req_ch.event_id = '0;
      req_ch.offset_ns = '0;
      req_ch.now_ns = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty run, extremes of every field, negative clamp, equal due
      // times, cancel of an idle slot, the unused code, and a run popping sixteen.
      send_request(FUNC_RUN, 4'd0, '0, '0);
      send_request(FUNC_CANCEL, 4'd3, '0, 63'd5);
      send_request(FUNC_SCHED, 4'd15, {1'b1, {47{1'b0}}}, 63'd10);
      send_request(FUNC_SCHED, 4'd0, {1'b0, {47{1'b1}}}, {63{1'b1}});
      send_request(FUNC_SCHED, 4'd5, 48'd20, 63'd100);
      send_request(FUNC_SCHED, 4'd6, 48'd20, 63'd100);
      send_request(FUNC_SCHED, 4'd5, -48'sd30, 63'd100);
      send_request(FUNC_SPARE, 4'd9, {48{1'b1}}, {63{1'b1}});
      send_request(FUNC_CANCEL, 4'd6, '0, 63'd100);
      send_request(FUNC_RUN, 4'd0, '0, 63'd200);
      send_request(FUNC_CANCEL, 4'd0, '0, 63'd200);
      for (int i = 0; i < 16; i++)
         send_request(FUNC_SCHED, 4'(i), 48'(i % 3), 63'd1000);
      send_request(FUNC_RUN, 4'd0, '0, {63{1'b1}});
      send_request(FUNC_RUN, 4'd0, '0, 63'd1000);

      // Random part in four idling phases.
      sim_now = 63'd2000;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 35 : 0;
         recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 35 : 0;
         repeat (25) send_random();
      end
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/setq_pkg.sv
hw/rtl/setq_if.sv
hw/rtl/setq_ram.sv
hw/rtl/sorted_event_timer_queue_unit.sv
bench/timer_queue_checker.sv
bench/testbench.sv
